// ===== design/wptc_pkg.sv =====
// shared types, constants and helpers for the windowed peak and trough counter
package wptc_pkg;

	localparam int WINDOW_LIMIT = 15;
	localparam int WINDOW_DEPTH = WINDOW_LIMIT + 1;
	localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
	localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
	localparam int PRICE_W      = 32;
	localparam int COUNT_W      = 5;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [PRICE_W-1:0] MIN_RESET = {1'b0, {(PRICE_W-1){1'b1}}};

	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	typedef logic signed [PRICE_W-1:0] price_t;
	typedef logic        [COUNT_W-1:0] count_t;
	typedef logic        [31:0]        total_t;
	typedef logic        [ADDR_W-1:0]  addr_t;
	typedef logic        [FILL_W-1:0]  fill_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	// control from the sequencer to the compare unit
	typedef struct packed {
		logic start;
		logic step;
		logic past_second;
	} scan_ctl_t;

	function automatic addr_t next_slot(input addr_t ptr);
		next_slot = (ptr == addr_t'(WINDOW_DEPTH - 1)) ? '0 : ptr + addr_t'(1);
	endfunction

endpackage

// ===== design/wptc_ram.sv =====
// generic single write port, single read port ram with registered read
module wptc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/wptc_scan.sv =====
// compare unit that walks the window one sample a cycle and counts turns
module wptc_scan (
	input  logic               clk,
	input  logic               arst_n,
	input  wptc_pkg::scan_ctl_t ctl,
	input  wptc_pkg::price_t   sample,
	output wptc_pkg::count_t   peaks,
	output wptc_pkg::count_t   troughs
);
	import wptc_pkg::*;

	price_t prev_q;
	logic   rising_q;
	count_t peaks_q;
	count_t troughs_q;
	logic   up;
	logic   down;

	// one signed comparator against the previous scanned sample
	always_comb begin
		up   = sample > prev_q;
		down = !up && (sample != prev_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= '0;
			rising_q  <= 1'b1;
			peaks_q   <= '0;
			troughs_q <= '0;
		end else if (ctl.start) begin
			prev_q    <= '0;
			rising_q  <= 1'b1;
			peaks_q   <= '0;
			troughs_q <= '0;
		end else if (ctl.step) begin
			prev_q <= sample;
			// flat runs keep the direction flag
			if (up) begin
				if (!rising_q && ctl.past_second && troughs_q != COUNT_MAX) begin
					troughs_q <= troughs_q + count_t'(1);
				end
				rising_q <= 1'b1;
			end
			if (down) begin
				if (rising_q && ctl.past_second && peaks_q != COUNT_MAX) begin
					peaks_q <= peaks_q + count_t'(1);
				end
				rising_q <= 1'b0;
			end
		end
	end

	assign peaks   = peaks_q;
	assign troughs = troughs_q;

endmodule

// ===== design/windowed_peak_trough_counter.sv =====
// top level of the windowed peak and trough counter
// An add word is taken, then every sample in the window, up to WINDOW_LIMIT+1
// once it is full, is read back through the single ram read port and compared
// once per cycle, then the scan drains and the result is loaded. A clear word
// goes straight to the result. in_stall stays high from acceptance until the
// result word sits in the output register; a result word waiting on out_stall
// holds the next word back only once that word has finished its scan, or at
// once if it is a clear word.
module windowed_peak_trough_counter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              action,
	input  wptc_pkg::price_t  price,
	output logic              out_valid,
	input  logic              out_stall,
	output wptc_pkg::count_t  peak_count,
	output wptc_pkg::count_t  trough_count,
	output wptc_pkg::price_t  price_low,
	output wptc_pkg::price_t  price_high,
	output logic              price_changing,
	output wptc_pkg::total_t  sample_total
);
	import wptc_pkg::*;

	state_t    state_q;
	state_t    state_d;
	scan_ctl_t scan_ctl;

	fill_t  fill_q;
	addr_t  oldest_q;
	addr_t  rd_ptr_q;
	addr_t  rd_idx_q;
	logic   vld_s1;
	logic   past_second_s1;

	price_t min_q;
	price_t max_q;
	price_t latest_q;
	price_t prev_q;
	total_t total_q;

	logic   out_valid_q;
	count_t peak_q;
	count_t trough_q;
	price_t min_out_q;
	price_t max_out_q;
	logic   changing_q;
	total_t total_out_q;

	logic   in_acc;
	logic   acc_add;
	logic   acc_clear;
	logic   full;
	logic   last_read;
	logic   out_free;
	logic   out_load;
	addr_t  wr_slot;
	addr_t  oldest_new;
	fill_t  fill_new;
	logic [ADDR_W:0] slot_sum;
	price_t rd_data;
	count_t scan_peaks;
	count_t scan_troughs;

	assign in_acc    = in_valid && !in_stall;
	assign acc_add   = in_acc && (action == ACT_ADD);
	assign acc_clear = in_acc && (action == ACT_CLEAR);
	assign full      = fill_q == fill_t'(WINDOW_DEPTH);
	assign last_read = fill_t'(rd_idx_q) == (fill_q - fill_t'(1));
	assign out_free  = !out_valid_q || !out_stall;

	// slot for the new sample: oldest + fill wrapped, or the oldest when full
	always_comb begin
		slot_sum = {1'b0, oldest_q} + {1'b0, fill_q[ADDR_W-1:0]};
		if (full) begin
			wr_slot    = oldest_q;
			oldest_new = next_slot(oldest_q);
			fill_new   = fill_q;
		end else begin
			if (slot_sum >= (ADDR_W+1)'(WINDOW_DEPTH)) begin
				wr_slot = ADDR_W'(slot_sum - (ADDR_W+1)'(WINDOW_DEPTH));
			end else begin
				wr_slot = slot_sum[ADDR_W-1:0];
			end
			oldest_new = oldest_q;
			fill_new   = fill_q + fill_t'(1);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc_add) begin
					state_d = ST_SCAN;
				end else if (acc_clear) begin
					state_d = ST_RESULT;
				end
			end
			ST_SCAN: begin
				if (last_read) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_RESULT: begin
				out_load = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
		scan_ctl.start       = acc_add;
		scan_ctl.step        = vld_s1;
		scan_ctl.past_second = past_second_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			fill_q         <= '0;
			oldest_q       <= '0;
			rd_ptr_q       <= '0;
			rd_idx_q       <= '0;
			vld_s1         <= 1'b0;
			past_second_s1 <= 1'b0;
			min_q          <= MIN_RESET;
			max_q          <= '0;
			latest_q       <= '0;
			prev_q         <= '0;
			total_q        <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q        <= state_d;
			vld_s1         <= state_q == ST_SCAN;
			past_second_s1 <= rd_idx_q > addr_t'(1);
			if (acc_add) begin
				fill_q   <= fill_new;
				oldest_q <= oldest_new;
				rd_ptr_q <= oldest_new;
				rd_idx_q <= '0;
				if (total_q != '1) begin
					total_q <= total_q + total_t'(1);
				end
				if (price < min_q) begin
					min_q <= price;
				end
				if (price > max_q) begin
					max_q <= price;
				end
				prev_q   <= latest_q;
				latest_q <= price;
			end else if (acc_clear) begin
				fill_q   <= '0;
				oldest_q <= '0;
			end
			if (state_q == ST_SCAN) begin
				rd_ptr_q <= next_slot(rd_ptr_q);
				rd_idx_q <= rd_idx_q + addr_t'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			peak_q      <= scan_peaks;
			trough_q    <= scan_troughs;
			min_out_q   <= min_q;
			max_out_q   <= max_q;
			changing_q  <= (total_q > total_t'(1)) && (latest_q != prev_q);
			total_out_q <= total_q;
		end
	end

	wptc_ram #(
		.WIDTH(PRICE_W),
		.DEPTH(WINDOW_DEPTH)
	) u_window (
		.clk  (clk),
		.we   (acc_add),
		.waddr(wr_slot),
		.wdata(price),
		.raddr(rd_ptr_q),
		.rdata(rd_data)
	);

	wptc_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.sample (rd_data),
		.peaks  (scan_peaks),
		.troughs(scan_troughs)
	);

	assign out_valid      = out_valid_q;
	assign peak_count     = peak_q;
	assign trough_count   = trough_q;
	assign price_low      = min_out_q;
	assign price_high     = max_out_q;
	assign price_changing = changing_q;
	assign sample_total   = total_out_q;

endmodule

// ===== design/wptc_checker.sv =====
// port level checks for the windowed peak and trough counter, bound to the top
module wptc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              action,
	input wptc_pkg::price_t  price,
	input logic              out_valid,
	input logic              out_stall,
	input wptc_pkg::count_t  peak_count,
	input wptc_pkg::count_t  trough_count,
	input wptc_pkg::price_t  price_low,
	input wptc_pkg::price_t  price_high,
	input logic              price_changing,
	input wptc_pkg::total_t  sample_total
);
	import wptc_pkg::*;

	// a stalled result word stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// one word at a time: input stalls right after a word is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while previous word still in work");

	// the running max has a floor of zero and, once a sample is seen, never lies below the min
	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (price_high >= 0) &&
			((sample_total == 0) || (price_low <= price_high)))
		else $error("min or max out of order");

	// turns cannot outnumber the window
	a_turns: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (10'(peak_count) + 10'(trough_count)) <= 10'(WINDOW_DEPTH))
		else $error("too many peaks and troughs for the window");

	// change flag needs at least two samples
	a_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && price_changing |-> sample_total > 32'd1)
		else $error("change flagged with fewer than two samples");

endmodule

bind windowed_peak_trough_counter wptc_checker u_wptc_checker (.*);

// ===== bench/tb_windowed_peak_trough_counter.sv =====
// self-checking testbench for the windowed peak and trough counter
module tb_windowed_peak_trough_counter;
	timeunit 1ns;
	timeprecision 1ps;

	import wptc_pkg::*;

	localparam int WORD_GOAL = 1950;

	typedef struct {
		logic   act;
		price_t p;
		logic   wait_drain;
	} word_t;

	typedef struct {
		count_t peaks;
		count_t troughs;
		price_t lo;
		price_t hi;
		logic   changing;
		total_t total;
	} tally_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_stall;
	logic     action = ACT_ADD;
	price_t   price = '0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	count_t   peak_count;
	count_t   trough_count;
	price_t   price_low;
	price_t   price_high;
	logic     price_changing;
	total_t   sample_total;

	word_t    words_to_send[$];
	tally_t   tallies_due[$];
	word_t    next_word;
	tally_t   want;

	logic     took_word = 1'b0;
	logic     took_action = ACT_ADD;
	price_t   took_price = '0;
	int       acc_count = 0;
	int       acc_now;
	int       res_count = 0;
	int       hold_left = 0;
	logic     hold_armed = 1'b1;
	int       errs = 0;
	int       word_total;

	// predictor state
	price_t   win_mem[WINDOW_DEPTH];
	int       win_fill;
	int       win_head;
	price_t   older_sample;
	price_t   newest_sample;
	total_t   seen_total;
	price_t   low_seen;
	price_t   high_seen;
	count_t   tops;
	count_t   bottoms;
	int       n_adds = 0;
	int       n_clears = 0;
	int       deepest_turns = 0;

	windowed_peak_trough_counter DUT (.*);

	always #1 clk = ~clk;

	task automatic queue_word(input logic act, input price_t p, input logic wait_drain);
		word_t w;
		w.act = act;
		w.p = p;
		w.wait_drain = wait_drain;
		words_to_send = {words_to_send, w};
	endtask

	task automatic advance_window(input logic act, input price_t p, output tally_t t);
		int i;
		price_t prior;
		logic rising;
		if (act == ACT_ADD) begin
			n_adds++;
			if (seen_total != '1)
				seen_total++;
			if (p < low_seen)
				low_seen = p;
			if (p > high_seen)
				high_seen = p;
			// full window drops its oldest sample first
			if (win_fill > WINDOW_LIMIT) begin
				win_head = (win_head + 1) % WINDOW_DEPTH;
				win_fill--;
			end
			win_mem[(win_head + win_fill) % WINDOW_DEPTH] = p;
			win_fill++;
			older_sample = newest_sample;
			newest_sample = p;
			// rescan oldest to newest, starting from zero and rising
			tops = '0;
			bottoms = '0;
			prior = '0;
			rising = 1'b1;
			for (i = 0; i < win_fill; i++) begin
				if (win_mem[(win_head + i) % WINDOW_DEPTH] > prior) begin
					if (!rising && i > 1 && bottoms < COUNT_MAX)
						bottoms++;
					rising = 1'b1;
				end
				if (win_mem[(win_head + i) % WINDOW_DEPTH] < prior) begin
					if (rising && i > 1 && tops < COUNT_MAX)
						tops++;
					rising = 1'b0;
				end
				prior = win_mem[(win_head + i) % WINDOW_DEPTH];
			end
			if (tops > deepest_turns)
				deepest_turns = tops;
			if (bottoms > deepest_turns)
				deepest_turns = bottoms;
		end else begin
			// clear empties the window and keeps everything else
			n_clears++;
			win_fill = 0;
			win_head = 0;
		end
		t.peaks = tops;
		t.troughs = bottoms;
		t.lo = low_seen;
		t.hi = high_seen;
		t.changing = (seen_total > 1) && (newest_sample != older_sample);
		t.total = seen_total;
	endtask

	task automatic compare_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected 0x%08h, got 0x%08h", name, exp_v, got_v);
			errs++;
		end
	endtask

	function automatic price_t pick_price(input int mode, input price_t last, input logic up);
		price_t v;
		case (mode)
			0: v = price_t'(int'($urandom_range(6)) - 3);
			1: v = price_t'($urandom);
			2: begin
				case ($urandom_range(4))
					0: v = price_t'(32'h8000_0000);
					1: v = price_t'(32'h7FFF_FFFF);
					2: v = '0;
					3: v = '1;
					default: v = price_t'(1);
				endcase
			end
			3: v = price_t'((int'($urandom_range(40)) - 20) * 65536
					+ int'($urandom_range(3)) * 16384);
			default: begin
				// zigzag with the odd flat step
				if ($urandom_range(4) == 0)
					v = last;
				else if (up)
					v = last + price_t'($urandom_range(1, 5000));
				else
					v = last - price_t'($urandom_range(1, 5000));
			end
		endcase
		return v;
	endfunction

	// driver: offers the next pending word once the current one is taken, subject to random gaps and drain waits
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= ACT_ADD;
			price <= '0;
			took_word <= 1'b0;
			acc_count <= 0;
		end else begin
			took_word <= in_valid && !in_stall;
			took_action <= action;
			took_price <= price;
			acc_now = acc_count + ((in_valid && !in_stall) ? 1 : 0);
			acc_count <= acc_now;
			if (!in_valid || !in_stall) begin
				if (words_to_send.size() != 0
						&& !(words_to_send[0].wait_drain && res_count != acc_now)
						&& ((acc_now >= 900 && acc_now < 1250) || $urandom_range(99) >= 34)) begin
					next_word = words_to_send.pop_front();
					in_valid <= 1'b1;
					action <= next_word.act;
					price <= next_word.p;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// one long receiver hold-off so the block backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_armed <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_armed && res_count == 400) begin
			hold_left <= 300;
			hold_armed <= 1'b0;
		end
	end

	// monitor: predicts each taken word, then checks each result word in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			res_count <= 0;
			win_fill = 0;
			win_head = 0;
			older_sample = '0;
			newest_sample = '0;
			seen_total = '0;
			low_seen = price_t'(MIN_RESET);
			high_seen = '0;
			tops = '0;
			bottoms = '0;
		end else begin
			if (took_word) begin
				advance_window(took_action, took_price, want);
				tallies_due = {tallies_due, want};
			end
			if (out_valid && !out_stall) begin
				res_count <= res_count + 1;
				if (tallies_due.size() == 0) begin
					$error("result word with nothing expected");
					errs++;
				end else begin
					want = tallies_due.pop_front();
					compare_field("peak_count", 32'(want.peaks), 32'(peak_count));
					compare_field("trough_count", 32'(want.troughs), 32'(trough_count));
					compare_field("price_low", want.lo, price_low);
					compare_field("price_high", want.hi, price_high);
					compare_field("price_changing", 32'(want.changing),
							32'(price_changing));
					compare_field("sample_total", want.total, sample_total);
				end
			end
			out_stall <= (hold_left != 0)
					|| (!(res_count >= 900 && res_count < 1250) && $urandom_range(99) < 34);
		end
	end

	initial begin
		int k;
		int burst;
		int mode;
		price_t v;
		logic up;
		logic paused;

		// nothing added yet, then extremes and flats
		queue_word(ACT_CLEAR, price_t'(32'h7FFF_FFFF), 1'b0);
		queue_word(ACT_ADD, '0, 1'b0);
		queue_word(ACT_ADD, '0, 1'b0);
		queue_word(ACT_ADD, price_t'(32'h7FFF_FFFF), 1'b0);
		queue_word(ACT_ADD, price_t'(32'h8000_0000), 1'b0);
		queue_word(ACT_ADD, '1, 1'b0);
		queue_word(ACT_ADD, price_t'(1), 1'b0);
		queue_word(ACT_ADD, price_t'(32'h0001_0000), 1'b0);
		queue_word(ACT_ADD, price_t'(32'h0001_0000), 1'b0);
		queue_word(ACT_ADD, price_t'(32'hFFFF_0000), 1'b0);
		// zigzag past a full window so the oldest sample drops out
		for (k = 0; k < 9; k++)
			queue_word(ACT_ADD, price_t'((k % 2) ? -(k * 3) : k * 3), 1'b0);
		queue_word(ACT_CLEAR, '0, 1'b0);
		queue_word(ACT_CLEAR, price_t'($urandom), 1'b0);
		// turn on the third element after a clear
		queue_word(ACT_ADD, price_t'(2), 1'b0);
		queue_word(ACT_ADD, price_t'(7), 1'b0);
		queue_word(ACT_ADD, price_t'(4), 1'b0);

		paused = 1'b0;
		v = '0;
		while (words_to_send.size() < WORD_GOAL) begin
			burst = $urandom_range(1, 40);
			mode = $urandom_range(5);
			up = 1'($urandom_range(1));
			for (k = 0; k < burst; k++) begin
				if (mode == 5) begin
					// noise: adds and clears mixed at random
					if ($urandom_range(1))
						queue_word(ACT_CLEAR, price_t'($urandom), 1'b0);
					else
						queue_word(ACT_ADD, price_t'($urandom), 1'b0);
				end else begin
					v = pick_price(mode, v, up);
					up = ~up;
					queue_word(ACT_ADD, v,
							(k == 0) && (($urandom_range(39) == 0)
							|| (!paused && words_to_send.size() >= 1500)));
					if (k == 0 && words_to_send.size() >= 1500)
						paused = 1'b1;
				end
			end
			if ($urandom_range(3) == 0)
				queue_word(ACT_CLEAR, price_t'($urandom), 1'b0);
		end
		word_total = words_to_send.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (res_count == word_total);
		repeat (40) @(posedge clk);
		@(negedge clk);
		if (tallies_due.size() != 0) begin
			$error("%0d result words never arrived", tallies_due.size());
			errs++;
		end
		$display("%0d words checked: %0d adds, %0d clears", res_count, n_adds, n_clears);
		$display("highest peak or trough count reached: %0d", deepest_turns);
		if (errs == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
design/wptc_pkg.sv
design/wptc_ram.sv
design/wptc_scan.sv
design/windowed_peak_trough_counter.sv
design/wptc_checker.sv
bench/tb_windowed_peak_trough_counter.sv
